// ===== rtl/core/lbsm_pkg.sv =====
`timescale 1ns / 1ps

package lbsm_pkg;

	localparam int SLOTS_DEF       = 23;
	localparam int MAX_BUFFERS_DEF = 1024;

	localparam int BUF_W      = 10;   // buffer number / tag width
	localparam int SLOT_IDX_W = 5;    // width of the slot_index result field
	localparam int TICK_W     = 31;   // tick saturates at 0x7FFFFFFF
	localparam logic [TICK_W-1:0] TICK_MAX = {TICK_W{1'b1}};

	// controller -> datapath
	typedef struct packed {
		logic load_req;    // capture incoming request
		logic classify;    // latch error / repeat-hit decision
		logic scan_start;  // clear scan trackers, counter to slot 0
		logic scan_step;   // examine one slot
		logic commit;      // update table, load result register
	} lbsm_cmd_t;

	// datapath -> controller
	typedef struct packed {
		logic err;         // request is out of range
		logic last_hit;    // repeat of the last buffer
		logic scan_done;   // counter sits on the last slot
		logic out_stall;   // result register full and not taken
	} lbsm_stat_t;

endpackage

// ===== rtl/core/lru_buffer_slot_manager_core.sv =====
`timescale 1ns / 1ps
// Channel   Handshake            Payload
// in        in_valid/in_ready    buffer_index[9:0]
// out       out_valid/out_ready  slot_index[4:0] hit filled_empty evicted
//                                evicted_buffer[9:0] allocated_new error
//
// A request that needs the slot scan (tag hit, empty fill or eviction) goes through
// accept, decide, one scan step per slot, then commit.
// A repeat of the last buffer or an out-of-range request skips the scan: accept, decide, then commit.
// arst_n clears all slots, the tick, the buffer count and the last-buffer record.
// The result register lets the next request enter while a result waits; commit
// holds until out_ready frees that register.

module lru_buffer_slot_manager_core #(
	parameter int SLOTS       = lbsm_pkg::SLOTS_DEF,
	parameter int MAX_BUFFERS = lbsm_pkg::MAX_BUFFERS_DEF
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            in_valid,
	output logic                            in_ready,
	input  logic [lbsm_pkg::BUF_W-1:0]      buffer_index,
	output logic                            out_valid,
	input  logic                            out_ready,
	output logic [lbsm_pkg::SLOT_IDX_W-1:0] slot_index,
	output logic                            hit,
	output logic                            filled_empty,
	output logic                            evicted,
	output logic [lbsm_pkg::BUF_W-1:0]      evicted_buffer,
	output logic                            allocated_new,
	output logic                            error
);

	lbsm_pkg::lbsm_cmd_t  cmd;
	lbsm_pkg::lbsm_stat_t stat;

	lbsm_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.stat     (stat),
		.cmd      (cmd)
	);

	lbsm_dpath #(
		.SLOTS       (SLOTS),
		.MAX_BUFFERS (MAX_BUFFERS)
	) u_dpath (
		.clk            (clk),
		.arst_n         (arst_n),
		.cmd            (cmd),
		.stat           (stat),
		.buffer_index   (buffer_index),
		.out_valid      (out_valid),
		.out_ready      (out_ready),
		.slot_index     (slot_index),
		.hit            (hit),
		.filled_empty   (filled_empty),
		.evicted        (evicted),
		.evicted_buffer (evicted_buffer),
		.allocated_new  (allocated_new),
		.error          (error)
	);

endmodule

// ===== rtl/core/lbsm_ctrl.sv =====
`timescale 1ns / 1ps

module lbsm_ctrl (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_ready,
	input  lbsm_pkg::lbsm_stat_t stat,
	output lbsm_pkg::lbsm_cmd_t  cmd
);

	localparam logic [1:0] ST_IDLE   = 2'd0;
	localparam logic [1:0] ST_DECIDE = 2'd1;
	localparam logic [1:0] ST_SCAN   = 2'd2;
	localparam logic [1:0] ST_DONE   = 2'd3;

	logic [1:0] state_q;
	logic [1:0] state_d;

	always_comb begin
		state_d  = state_q;
		cmd      = '0;
		in_ready = 1'b0;
		case (state_q)
			ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.load_req = 1'b1;
					state_d      = ST_DECIDE;
				end
			end
			ST_DECIDE: begin
				cmd.classify = 1'b1;
				if (stat.err || stat.last_hit) begin
					state_d = ST_DONE;
				end else begin
					cmd.scan_start = 1'b1;
					state_d        = ST_SCAN;
				end
			end
			ST_SCAN: begin
				cmd.scan_step = 1'b1;
				if (stat.scan_done) begin
					state_d = ST_DONE;
				end
			end
			ST_DONE: begin
				if (!stat.out_stall) begin
					cmd.commit = 1'b1;
					state_d    = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

endmodule

// ===== rtl/core/lbsm_dpath.sv =====
`timescale 1ns / 1ps

module lbsm_dpath #(
	parameter int SLOTS       = lbsm_pkg::SLOTS_DEF,
	parameter int MAX_BUFFERS = lbsm_pkg::MAX_BUFFERS_DEF
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  lbsm_pkg::lbsm_cmd_t                 cmd,
	output lbsm_pkg::lbsm_stat_t                stat,
	input  logic [lbsm_pkg::BUF_W-1:0]          buffer_index,
	output logic                                out_valid,
	input  logic                                out_ready,
	output logic [lbsm_pkg::SLOT_IDX_W-1:0]     slot_index,
	output logic                                hit,
	output logic                                filled_empty,
	output logic                                evicted,
	output logic [lbsm_pkg::BUF_W-1:0]          evicted_buffer,
	output logic                                allocated_new,
	output logic                                error
);

	localparam int SLOT_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;
	localparam int SLOT_XW = (SLOT_W > lbsm_pkg::SLOT_IDX_W) ? SLOT_W : lbsm_pkg::SLOT_IDX_W;
	localparam int BC_W   = $clog2(MAX_BUFFERS + 1);
	localparam int CMP_W  = (BC_W > lbsm_pkg::BUF_W) ? BC_W : lbsm_pkg::BUF_W;
	localparam int BW     = lbsm_pkg::BUF_W;
	localparam int TW     = lbsm_pkg::TICK_W;

	// slot table: valid bits reset, tags/stamps only read once written
	logic              valid_q [SLOTS];
	logic [BW-1:0]     tag_q   [SLOTS];
	logic [TW-1:0]     stamp_q [SLOTS];

	logic [TW-1:0]     tick_q;
	logic [BC_W-1:0]   bc_q;
	logic              last_valid_q;
	logic [BW-1:0]     last_tag_q;
	logic [SLOT_W-1:0] last_slot_q;

	logic [BW-1:0]     req_q;
	logic              err_q;
	logic              lhit_q;

	// scan trackers
	logic [SLOT_W-1:0] cnt_q;
	logic              mfound_q;
	logic [SLOT_W-1:0] mslot_q;
	logic              efound_q;
	logic [SLOT_W-1:0] eslot_q;
	logic [SLOT_W-1:0] min_slot_q;
	logic [TW-1:0]     min_stamp_q;
	logic [BW-1:0]     min_tag_q;

	// result register
	logic              out_valid_q;
	logic [SLOT_W-1:0] res_slot_q;
	logic              res_hit_q;
	logic              res_fill_q;
	logic              res_evict_q;
	logic [BW-1:0]     res_vic_q;
	logic              res_alloc_q;
	logic              res_err_q;

	logic [CMP_W-1:0]  req_x;
	logic [CMP_W-1:0]  bc_x;
	logic              err_c;
	logic              lhit_c;
	logic              alloc_c;
	logic [TW-1:0]     tick_n;
	logic [SLOT_W-1:0] sel_slot;
	logic              cur_valid;
	logic [BW-1:0]     cur_tag;
	logic [TW-1:0]     cur_stamp;
	logic [SLOT_XW-1:0] slot_ext;

	assign req_x  = CMP_W'(req_q);
	assign bc_x   = CMP_W'(bc_q);
	assign err_c  = (req_x > bc_x) ||
		((req_x == bc_x) && (bc_q >= BC_W'(MAX_BUFFERS)));
	assign lhit_c = last_valid_q && (req_q == last_tag_q);
	assign alloc_c = !lhit_q && (req_x == bc_x);
	assign tick_n = (tick_q == lbsm_pkg::TICK_MAX) ? tick_q : tick_q + 1'b1;

	assign cur_valid = valid_q[cnt_q];
	assign cur_tag   = tag_q[cnt_q];
	assign cur_stamp = stamp_q[cnt_q];

	always_comb begin
		if (lhit_q) begin
			sel_slot = last_slot_q;
		end else if (mfound_q) begin
			sel_slot = mslot_q;
		end else if (efound_q) begin
			sel_slot = eslot_q;
		end else begin
			sel_slot = min_slot_q;
		end
	end

	assign stat.err       = err_c;
	assign stat.last_hit  = lhit_c;
	assign stat.scan_done = (cnt_q == SLOT_W'(SLOTS - 1));
	assign stat.out_stall = out_valid_q && !out_ready;

	always_ff @(posedge clk) begin
		if (cmd.load_req) begin
			req_q <= buffer_index;
		end
		if (cmd.classify) begin
			err_q  <= err_c;
			lhit_q <= lhit_c;
		end
		if (cmd.scan_step) begin
			// strict compare keeps the lowest slot on equal stamps
			if ((cnt_q == '0) || (cur_stamp < min_stamp_q)) begin
				min_slot_q  <= cnt_q;
				min_stamp_q <= cur_stamp;
				min_tag_q   <= cur_tag;
			end
			if (cur_valid && (cur_tag == req_q) && !mfound_q) begin
				mslot_q <= cnt_q;
			end
			if (!cur_valid && !efound_q) begin
				eslot_q <= cnt_q;
			end
		end
		if (cmd.commit && !err_q) begin
			stamp_q[sel_slot] <= tick_n;
			if (!lhit_q) begin
				tag_q[sel_slot] <= req_q;
			end
		end
		if (cmd.commit) begin
			res_err_q   <= err_q;
			res_slot_q  <= err_q ? '0 : sel_slot;
			res_hit_q   <= !err_q && (lhit_q || mfound_q);
			res_fill_q  <= !err_q && !lhit_q && !mfound_q && efound_q;
			res_evict_q <= !err_q && !lhit_q && !mfound_q && !efound_q;
			res_vic_q   <= (!err_q && !lhit_q && !mfound_q && !efound_q) ? min_tag_q : '0;
			res_alloc_q <= !err_q && alloc_c;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < SLOTS; i++) begin
				valid_q[i] <= 1'b0;
			end
			tick_q       <= '0;
			bc_q         <= '0;
			last_valid_q <= 1'b0;
			last_tag_q   <= '0;
			last_slot_q  <= '0;
			cnt_q        <= '0;
			mfound_q     <= 1'b0;
			efound_q     <= 1'b0;
			out_valid_q  <= 1'b0;
		end else begin
			if (cmd.scan_start) begin
				cnt_q    <= '0;
				mfound_q <= 1'b0;
				efound_q <= 1'b0;
			end else if (cmd.scan_step) begin
				if (cur_valid && (cur_tag == req_q)) begin
					mfound_q <= 1'b1;
				end
				if (!cur_valid) begin
					efound_q <= 1'b1;
				end
				if (!stat.scan_done) begin
					cnt_q <= cnt_q + 1'b1;
				end
			end
			if (cmd.commit && !err_q) begin
				tick_q       <= tick_n;
				last_valid_q <= 1'b1;
				last_tag_q   <= req_q;
				last_slot_q  <= sel_slot;
				valid_q[sel_slot] <= 1'b1;
				if (alloc_c) begin
					bc_q <= bc_q + 1'b1;
				end
			end
			if (cmd.commit) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign slot_ext       = SLOT_XW'(res_slot_q);
	assign out_valid      = out_valid_q;
	assign slot_index     = slot_ext[lbsm_pkg::SLOT_IDX_W-1:0];
	assign hit            = res_hit_q;
	assign filled_empty   = res_fill_q;
	assign evicted        = res_evict_q;
	assign evicted_buffer = res_vic_q;
	assign allocated_new  = res_alloc_q;
	assign error          = res_err_q;

	a_commit_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.commit |-> !(out_valid_q && !out_ready))
		else $error("result register overwritten before taken");

	a_one_outcome: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q |-> ($countones({res_hit_q, res_fill_q, res_evict_q, res_err_q}) == 1))
		else $error("result must carry exactly one outcome");

	a_victim_only_on_evict: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && !res_evict_q) |-> (res_vic_q == '0))
		else $error("victim buffer reported without eviction");

	a_tick_monotonic: assert property (@(posedge clk) disable iff (!arst_n)
		1'b1 |=> (tick_q >= $past(tick_q)))
		else $error("tick counter went backwards");

	a_count_bounded: assert property (@(posedge clk) disable iff (!arst_n)
		bc_q <= BC_W'(MAX_BUFFERS))
		else $error("buffer count beyond table size");

endmodule
